/* hdl/rtppk_pkg.sv */
// Shared types and constants for the RTP packetiser.
`timescale 1ns / 1ps
package rtppk_pkg;

  localparam int LENGTH_BITS_DEFAULT = 24;
  localparam int FRAME_LEN_W         = 24;
  localparam int PAYLOAD_W           = 11;
  localparam int PT_W                = 7;
  localparam int SEQ_W               = 16;
  localparam int TS_W                = 32;
  localparam int SSRC_W              = 32;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 32;
  localparam int HDR_CNT_W           = 4;

  localparam logic [HDR_CNT_W-1:0] HDR_BYTES         = 4'd12;
  localparam logic [7:0]           VERSION_BYTE      = 8'h80;
  localparam logic [PT_W-1:0]      PT_RESET          = 7'd96;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_CAP_RESET = 11'd1400;
  localparam logic [CFG_DATA_W-1:0] PT_MASK          = 32'h0000_007F;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_SSRC         = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_CAP  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_TYPE = 2'd2;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [TS_W-1:0]        timestamp;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       run_last;
  } pkt_item_t;

  typedef struct packed {
    logic [SSRC_W-1:0]    ssrc;
    logic [PAYLOAD_W-1:0] payload_cap;
    logic [PT_W-1:0]      payload_type;
  } cfg_t;

  // One accepted byte with everything its packet words need but the SSRC
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             opens;
    logic [7:0]       hdr_b1;
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  timestamp;
    logic             pkt_end;
  } job_t;

endpackage

/* hdl/rtp_packetizer_core.sv */
// RTP packetiser top level: configuration registers, framer and output serialiser.
// Bytes of a frame enter on the byte channel, one word per byte, tagged with the frame length
// and timestamp; packet words leave on the pkt channel. A byte that continues a packet gives one
// output word; a byte that opens a packet gives thirteen (twelve RTP header words, then the byte);
// the single output port emits one word per cycle unless stalled. Bytes pass the job and cur
// registers, and one further byte is taken while the output is stalled. Registers ssrc, payload cap
// and payload_type must be written on the cfg port only while the block is idle; it does not check.
`timescale 1ns / 1ps
module rtp_packetizer_core #(
  parameter int LENGTH_BITS = rtppk_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rtppk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rtppk_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             byte_valid,
  output logic                             byte_stall,
  input  rtppk_pkg::byte_item_t            byte_data,
  output logic                             pkt_valid,
  input  logic                             pkt_stall,
  output rtppk_pkg::pkt_item_t             pkt_data
);
  import rtppk_pkg::*;

  cfg_t cfg;
  job_t job;
  logic job_valid, ser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ssrc         <= '0;
      cfg.payload_cap  <= PAYLOAD_CAP_RESET;
      cfg.payload_type <= PT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SSRC:         cfg.ssrc         <= cfg_data;
        REG_PAYLOAD_CAP:  cfg.payload_cap  <= cfg_data[PAYLOAD_W-1:0];
        REG_PAYLOAD_TYPE: cfg.payload_type <= PT_W'(cfg_data & PT_MASK);
        default: ;
      endcase
    end
  end

  rtppk_framer #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .job_valid  (job_valid),
    .job        (job),
    .ser_ready  (ser_ready)
  );

  rtppk_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .ssrc      (cfg.ssrc),
    .job_valid (job_valid),
    .job       (job),
    .ser_ready (ser_ready),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt_data  (pkt_data)
  );

endmodule

/* hdl/rtppk_framer.sv */
// Frame and packet bookkeeping: decides packet boundaries and registers one job per byte.
`timescale 1ns / 1ps
module rtppk_framer #(
  parameter int LENGTH_BITS = rtppk_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rtppk_pkg::cfg_t      cfg,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  rtppk_pkg::byte_item_t byte_data,
  output logic                 job_valid,
  output rtppk_pkg::job_t      job,
  input  logic                 ser_ready
);
  import rtppk_pkg::*;

  localparam int EXT_W = LENGTH_BITS + FRAME_LEN_W;

  logic [SEQ_W-1:0]       sequence_number, sequence_number_next;
  logic [LENGTH_BITS-1:0] frame_offset, frame_offset_next;
  logic [PAYLOAD_W-1:0]   payload_left, payload_left_next;

  logic [EXT_W-1:0]       flen_ext;
  logic [LENGTH_BITS-1:0] flen_raw, flen, base_off, remaining, off_inc, cap_ext;
  logic [PAYLOAD_W-1:0]   cap, chunk, pl_cur, pl_dec;
  logic                   opening, marker, frame_done, pkt_end, accept;

  assign byte_stall = job_valid && !ser_ready;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    flen_ext  = {{LENGTH_BITS{1'b0}}, byte_data.frame_length};
    flen_raw  = flen_ext[LENGTH_BITS-1:0];
    // a zero length counts as a one-byte frame
    flen      = (flen_raw == '0) ? LENGTH_BITS'(1) : flen_raw;
    cap       = (cfg.payload_cap == '0) ? PAYLOAD_W'(1) : cfg.payload_cap;
    cap_ext   = LENGTH_BITS'(cap);
    opening   = (payload_left == '0);
    // at a packet opening, restart the frame if the length is no longer above the offset
    base_off  = (opening && (frame_offset >= flen)) ? '0 : frame_offset;
    remaining = flen - base_off;
    marker    = (remaining <= cap_ext);
    chunk     = marker ? remaining[PAYLOAD_W-1:0] : cap;
    pl_cur    = opening ? chunk : payload_left;
    pl_dec    = pl_cur - PAYLOAD_W'(1);
    off_inc   = base_off + LENGTH_BITS'(1);
    frame_done = (off_inc >= flen) || (off_inc == '0);
    frame_offset_next    = frame_done ? '0 : off_inc;
    payload_left_next    = frame_done ? '0 : pl_dec;
    pkt_end              = frame_done || (pl_dec == '0);
    sequence_number_next = sequence_number + SEQ_W'(opening);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= '0;
      frame_offset    <= '0;
      payload_left    <= '0;
      job_valid       <= 1'b0;
    end else begin
      if (accept) begin
        sequence_number <= sequence_number_next;
        frame_offset    <= frame_offset_next;
        payload_left    <= payload_left_next;
        job_valid       <= 1'b1;
      end else if (ser_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.data_byte <= byte_data.data_byte;
      job.opens     <= opening;
      job.hdr_b1    <= {marker, cfg.payload_type};
      job.seq       <= sequence_number;
      job.timestamp <= byte_data.timestamp;
      job.pkt_end   <= pkt_end;
    end
  end

`ifndef SYNTH
  // an open packet always sits inside a frame that has begun
  a_open_in_frame: assert property (@(posedge clk) disable iff (rst)
    (payload_left != '0) |-> (frame_offset != '0))
    else $error("payload open at frame offset zero");

  // a held job is never overwritten
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !ser_ready) |=> (job_valid && $stable(job)))
    else $error("pending job lost");

  // stall only while a job waits
  a_stall_needs_job: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> job_valid)
    else $error("input stalled with no job held");
`endif

endmodule

/* hdl/rtppk_serializer.sv */
// Output stage: emits the twelve header words of an opening job and the payload word of each job.
`timescale 1ns / 1ps
module rtppk_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic [rtppk_pkg::SSRC_W-1:0] ssrc,
  input  logic                job_valid,
  input  rtppk_pkg::job_t     job,
  output logic                ser_ready,
  output logic                pkt_valid,
  input  logic                pkt_stall,
  output rtppk_pkg::pkt_item_t pkt_data
);
  import rtppk_pkg::*;

  job_t                        cur;
  logic                        busy;
  logic [HDR_CNT_W-1:0]        hdr_left;
  logic [HDR_BYTES-1:0][7:0]   hdr_bytes;
  logic                        payload_word;

  assign payload_word = (hdr_left == '0);
  assign ser_ready    = !busy || (!pkt_stall && payload_word);
  assign hdr_bytes    = {VERSION_BYTE, cur.hdr_b1, cur.seq, cur.timestamp, ssrc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      hdr_left <= '0;
    end else if (ser_ready) begin
      busy     <= job_valid;
      hdr_left <= (job_valid && job.opens) ? HDR_BYTES : '0;
    end else if (!pkt_stall) begin
      hdr_left <= hdr_left - HDR_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_ready && job_valid) begin
      cur <= job;
    end
  end

  always_comb begin
    pkt_valid             = busy;
    pkt_data.out_byte     = payload_word ? cur.data_byte
                                         : hdr_bytes[hdr_left - HDR_CNT_W'(1)];
    pkt_data.packet_start = (hdr_left == HDR_BYTES);
    pkt_data.packet_end   = payload_word && cur.pkt_end;
    pkt_data.run_last     = payload_word;
  end

`ifndef SYNTH
  a_hdr_only_when_open: assert property (@(posedge clk) disable iff (rst)
    (hdr_left != '0) |-> (busy && cur.opens))
    else $error("header word without an opening byte");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (busy && !pkt_stall && !payload_word) |=> (busy && (hdr_left == $past(hdr_left) - 4'd1)))
    else $error("word run broken before its last word");

  a_start_advances: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && !pkt_stall && pkt_data.packet_start) |=> (pkt_valid && !pkt_data.packet_start
      && !pkt_data.run_last))
    else $error("header cut short after first word");
`endif

endmodule
